/* rtl/lz4bd_pkg.sv */
// Shared types, constants and codes for the LZ4 block decompressor.
package lz4bd_pkg;

    // History window; the depth must be a power of two so the ring pointers wrap freely.
    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

    // Largest number of match bytes produced by one drain transfer.
    localparam int DRAIN_BURST  = 64;
    localparam int BURST_W      = $clog2(DRAIN_BURST + 1);

    localparam int LEN_W        = 32;
    localparam int OUT_DATA_W   = 48;

    localparam logic [3:0] NIBBLE_EXT = 4'hF;
    localparam logic [7:0] BYTE_EXT   = 8'hFF;
    localparam int         MIN_MATCH  = 4;

    // Decoder phase within the compressed stream.
    typedef enum logic [3:0] {
        PH_TOKEN     = 4'd0,
        PH_LIT_EXT   = 4'd1,
        PH_LITERAL   = 4'd2,
        PH_OFF_LO    = 4'd3,
        PH_OFF_HI    = 4'd4,
        PH_MATCH_EXT = 4'd5,
        PH_COPY      = 4'd6,
        PH_DISCARD   = 4'd7
    } phase_t;

    // Result status codes.
    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_ZERO_OFF = 3'd1,
        STS_FAR_OFF  = 3'd2,
        STS_TRUNC    = 3'd3,
        STS_BUSY     = 3'd4,
        STS_DISCARD  = 3'd5
    } status_t;

    // Sequencer steps.
    typedef enum logic [2:0] {
        SQ_IDLE = 3'd0,
        SQ_EXEC = 3'd1,
        SQ_RD   = 3'd2,
        SQ_CWR  = 3'd3,
        SQ_CNT  = 3'd4,
        SQ_PUT  = 3'd5
    } seq_t;

    // Operations of the shared adder.
    typedef enum logic [1:0] {
        ALU_INC     = 2'd0,
        ALU_ADD_SAT = 2'd1,
        ALU_SUB     = 2'd2
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [LEN_W-1:0]   a;
        logic [LEN_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic [LEN_W-1:0]   result;
        logic               carry;   // carry out; for a subtract, 1 means no borrow
    } alu_rsp_t;

endpackage

/* rtl/lz4_block_decompressor_core.sv */
// Top level of the LZ4 block decompressor: sequencer, state and output register.
//
//  Channel   Direction  Handshake               Payload
//  s_axis    in         s_axis_tvalid/tready    tdata: comp_byte; tuser: req_type;
//                                               tlast: last_byte
//  m_axis    out        m_axis_tvalid/tready    tdata: out_byte, status, block_done,
//                                               copy_pending, total_out;
//                                               tuser: byte_valid; tlast: run_end
//
// A compressed byte passes from its transfer through the execute step to the result
// step, which loads it into the output register; a literal also passes the count step.
// A drain transfer passes the execute step, then per copied byte a window read, a window
// write with length decrement, a count increment and a result load, since one shared adder
// and one window serve every step. The input is ready only while the sequencer is idle.
// Reset clears the phase, the counters and the ring pointers; the window memory is not
// cleared and reads as undefined until written. A stall on the output holds the
// sequencer in its result step; an input transfer is still taken while the last
// result waits in the output register.
module lz4_block_decompressor_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] comp_byte
    input  logic        s_axis_tuser,   // [0] req_type
    input  logic        s_axis_tlast,   // last_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status, [11] block_done,
                                        // [12] copy_pending, [44:13] total_out, [47:45] zero
    output logic        m_axis_tuser,   // [0] byte_valid
    output logic        m_axis_tlast    // run_end
);

    localparam int AW  = lz4bd_pkg::WIN_AW;
    localparam int LW  = lz4bd_pkg::LEN_W;
    localparam int BW  = lz4bd_pkg::BURST_W;

    // Sequencer and decoder state.
    lz4bd_pkg::seq_t    state_reg, state_next;
    lz4bd_pkg::phase_t  phase_reg, phase_next;
    logic [LW-1:0]      literal_left_reg, literal_left_next;
    logic [LW-1:0]      match_left_reg, match_left_next;
    logic [3:0]         match_nibble_reg, match_nibble_next;
    logic [15:0]        offset_reg, offset_next;
    logic [AW-1:0]      write_ptr_reg, write_ptr_next;
    logic [AW-1:0]      read_ptr_reg, read_ptr_next;
    logic [LW-1:0]      emitted_count_reg, emitted_count_next;
    logic               end_seen_reg, end_seen_next;
    logic [BW-1:0]      burst_cnt_reg, burst_cnt_next;

    // The accepted input transfer.
    logic               req_reg, req_next;
    logic [7:0]         in_byte_reg, in_byte_next;
    logic               last_reg, last_next;

    // The result being built.
    logic [7:0]         res_byte_reg, res_byte_next;
    logic               res_valid_reg, res_valid_next;
    lz4bd_pkg::status_t res_status_reg, res_status_next;
    logic               res_done_reg, res_done_next;
    logic               res_run_end_reg, res_run_end_next;
    logic               res_end_block_reg, res_end_block_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [lz4bd_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic               out_user_reg, out_user_next;
    logic               out_last_reg, out_last_next;

    // Shared adder and window port.
    lz4bd_pkg::alu_req_t alu_req;
    lz4bd_pkg::alu_rsp_t alu_rsp;
    logic               win_wr_en;
    logic [7:0]         win_wr_data;
    logic               win_rd_en;
    logic [7:0]         win_rd_data;

    logic               put_ok;
    logic [15:0]        offset_full;
    lz4bd_pkg::phase_t  phase_dec;
    lz4bd_pkg::status_t err;
    logic               lit_valid;

    lz4bd_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    lz4bd_window u_window
    (
        .clk     (clk),
        .wr_en   (win_wr_en),
        .wr_addr (write_ptr_reg),
        .wr_data (win_wr_data),
        .rd_en   (win_rd_en),
        .rd_addr (read_ptr_reg),
        .rd_data (win_rd_data)
    );

    assign s_axis_tready = (state_reg == lz4bd_pkg::SQ_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // The result step may load the output register when it is empty or being drained.
    assign put_ok      = !out_valid_reg || m_axis_tready;
    assign offset_full = {in_byte_reg, offset_reg[7:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= lz4bd_pkg::SQ_IDLE;
            phase_reg         <= lz4bd_pkg::PH_TOKEN;
            literal_left_reg  <= '0;
            match_left_reg    <= '0;
            match_nibble_reg  <= '0;
            offset_reg        <= '0;
            write_ptr_reg     <= '0;
            read_ptr_reg      <= '0;
            emitted_count_reg <= '0;
            end_seen_reg      <= 1'b0;
            burst_cnt_reg     <= '0;
            req_reg           <= 1'b0;
            in_byte_reg       <= '0;
            last_reg          <= 1'b0;
            res_byte_reg      <= '0;
            res_valid_reg     <= 1'b0;
            res_status_reg    <= lz4bd_pkg::STS_OK;
            res_done_reg      <= 1'b0;
            res_run_end_reg   <= 1'b0;
            res_end_block_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_data_reg      <= '0;
            out_user_reg      <= 1'b0;
            out_last_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            literal_left_reg  <= literal_left_next;
            match_left_reg    <= match_left_next;
            match_nibble_reg  <= match_nibble_next;
            offset_reg        <= offset_next;
            write_ptr_reg     <= write_ptr_next;
            read_ptr_reg      <= read_ptr_next;
            emitted_count_reg <= emitted_count_next;
            end_seen_reg      <= end_seen_next;
            burst_cnt_reg     <= burst_cnt_next;
            req_reg           <= req_next;
            in_byte_reg       <= in_byte_next;
            last_reg          <= last_next;
            res_byte_reg      <= res_byte_next;
            res_valid_reg     <= res_valid_next;
            res_status_reg    <= res_status_next;
            res_done_reg      <= res_done_next;
            res_run_end_reg   <= res_run_end_next;
            res_end_block_reg <= res_end_block_next;
            out_valid_reg     <= out_valid_next;
            out_data_reg      <= out_data_next;
            out_user_reg      <= out_user_next;
            out_last_reg      <= out_last_next;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        phase_next         = phase_reg;
        literal_left_next  = literal_left_reg;
        match_left_next    = match_left_reg;
        match_nibble_next  = match_nibble_reg;
        offset_next        = offset_reg;
        write_ptr_next     = write_ptr_reg;
        read_ptr_next      = read_ptr_reg;
        emitted_count_next = emitted_count_reg;
        end_seen_next      = end_seen_reg;
        burst_cnt_next     = burst_cnt_reg;
        req_next           = req_reg;
        in_byte_next       = in_byte_reg;
        last_next          = last_reg;
        res_byte_next      = res_byte_reg;
        res_valid_next     = res_valid_reg;
        res_status_next    = res_status_reg;
        res_done_next      = res_done_reg;
        res_run_end_next   = res_run_end_reg;
        res_end_block_next = res_end_block_reg;
        out_valid_next     = out_valid_reg && !m_axis_tready;
        out_data_next      = out_data_reg;
        out_user_next      = out_user_reg;
        out_last_next      = out_last_reg;

        alu_req.op  = lz4bd_pkg::ALU_INC;
        alu_req.a   = emitted_count_reg;
        alu_req.b   = '0;
        win_wr_en   = 1'b0;
        win_wr_data = in_byte_reg;
        win_rd_en   = 1'b0;
        phase_dec   = phase_reg;
        err         = lz4bd_pkg::STS_OK;
        lit_valid   = 1'b0;

        case (state_reg)
            lz4bd_pkg::SQ_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next     = s_axis_tuser;
                    in_byte_next = s_axis_tdata;
                    last_next    = s_axis_tlast;
                    state_next   = lz4bd_pkg::SQ_EXEC;
                end
            end

            lz4bd_pkg::SQ_EXEC:
            begin
                res_byte_next      = '0;
                res_valid_next     = 1'b0;
                res_status_next    = lz4bd_pkg::STS_OK;
                res_done_next      = 1'b0;
                res_run_end_next   = 1'b1;
                res_end_block_next = 1'b0;
                state_next         = lz4bd_pkg::SQ_PUT;
                if (req_reg)
                begin
                    // Drain transfer: start a burst, or answer at once with no byte.
                    if (phase_reg == lz4bd_pkg::PH_COPY)
                    begin
                        burst_cnt_next = '0;
                        state_next     = lz4bd_pkg::SQ_RD;
                    end
                    else if (phase_reg == lz4bd_pkg::PH_DISCARD)
                    begin
                        res_status_next = lz4bd_pkg::STS_DISCARD;
                    end
                end
                else if (phase_reg == lz4bd_pkg::PH_COPY)
                begin
                    res_status_next = lz4bd_pkg::STS_BUSY;
                end
                else if (phase_reg == lz4bd_pkg::PH_DISCARD)
                begin
                    res_status_next    = lz4bd_pkg::STS_DISCARD;
                    res_end_block_next = last_reg;
                end
                else
                begin
                    case (phase_reg)
                        lz4bd_pkg::PH_TOKEN:
                        begin
                            literal_left_next = {{(LW-4){1'b0}}, in_byte_reg[7:4]};
                            match_nibble_next = in_byte_reg[3:0];
                            if (in_byte_reg[7:4] == lz4bd_pkg::NIBBLE_EXT)
                            begin
                                phase_dec = lz4bd_pkg::PH_LIT_EXT;
                            end
                            else if (in_byte_reg[7:4] != 4'd0)
                            begin
                                phase_dec = lz4bd_pkg::PH_LITERAL;
                            end
                            else
                            begin
                                phase_dec = lz4bd_pkg::PH_OFF_LO;
                            end
                        end
                        lz4bd_pkg::PH_LIT_EXT:
                        begin
                            alu_req.op        = lz4bd_pkg::ALU_ADD_SAT;
                            alu_req.a         = literal_left_reg;
                            alu_req.b         = {{(LW-8){1'b0}}, in_byte_reg};
                            literal_left_next = alu_rsp.result;
                            if (in_byte_reg != lz4bd_pkg::BYTE_EXT)
                            begin
                                phase_dec = (alu_rsp.result != '0) ? lz4bd_pkg::PH_LITERAL
                                                                   : lz4bd_pkg::PH_OFF_LO;
                            end
                        end
                        lz4bd_pkg::PH_LITERAL:
                        begin
                            win_wr_en         = 1'b1;
                            write_ptr_next    = write_ptr_reg + AW'(1);
                            lit_valid         = 1'b1;
                            alu_req.op        = lz4bd_pkg::ALU_SUB;
                            alu_req.a         = literal_left_reg;
                            alu_req.b         = LW'(1);
                            literal_left_next = alu_rsp.result;
                            if (alu_rsp.result == '0)
                            begin
                                phase_dec = lz4bd_pkg::PH_OFF_LO;
                            end
                        end
                        lz4bd_pkg::PH_OFF_LO:
                        begin
                            offset_next = {8'd0, in_byte_reg};
                            phase_dec   = lz4bd_pkg::PH_OFF_HI;
                        end
                        lz4bd_pkg::PH_OFF_HI:
                        begin
                            // Window depth minus offset borrows when the offset reaches too far.
                            offset_next = offset_full;
                            alu_req.op  = lz4bd_pkg::ALU_SUB;
                            alu_req.a   = LW'(lz4bd_pkg::WINDOW_DEPTH);
                            alu_req.b   = {{(LW-16){1'b0}}, offset_full};
                            if (offset_full == 16'd0)
                            begin
                                err = lz4bd_pkg::STS_ZERO_OFF;
                            end
                            else if (!alu_rsp.carry)
                            begin
                                err = lz4bd_pkg::STS_FAR_OFF;
                            end
                            else
                            begin
                                match_left_next = LW'(lz4bd_pkg::MIN_MATCH)
                                                + {{(LW-4){1'b0}}, match_nibble_reg};
                                read_ptr_next   = write_ptr_reg - offset_full[AW-1:0];
                                phase_dec = (match_nibble_reg == lz4bd_pkg::NIBBLE_EXT)
                                          ? lz4bd_pkg::PH_MATCH_EXT : lz4bd_pkg::PH_COPY;
                            end
                        end
                        default:
                        begin
                            alu_req.op      = lz4bd_pkg::ALU_ADD_SAT;
                            alu_req.a       = match_left_reg;
                            alu_req.b       = {{(LW-8){1'b0}}, in_byte_reg};
                            match_left_next = alu_rsp.result;
                            if (in_byte_reg != lz4bd_pkg::BYTE_EXT)
                            begin
                                phase_dec = lz4bd_pkg::PH_COPY;
                            end
                        end
                    endcase

                    res_valid_next = lit_valid;
                    res_byte_next  = lit_valid ? in_byte_reg : 8'd0;
                    if (err != lz4bd_pkg::STS_OK)
                    begin
                        phase_next         = lz4bd_pkg::PH_DISCARD;
                        res_status_next    = err;
                        res_end_block_next = last_reg;
                    end
                    else if (last_reg)
                    begin
                        // A block may end after its literals or after a whole match header.
                        if (phase_dec == lz4bd_pkg::PH_OFF_LO)
                        begin
                            phase_next         = lz4bd_pkg::PH_TOKEN;
                            res_done_next      = 1'b1;
                            res_end_block_next = 1'b1;
                        end
                        else if (phase_dec == lz4bd_pkg::PH_COPY)
                        begin
                            phase_next    = lz4bd_pkg::PH_COPY;
                            end_seen_next = 1'b1;
                        end
                        else
                        begin
                            phase_next         = lz4bd_pkg::PH_TOKEN;
                            res_status_next    = lz4bd_pkg::STS_TRUNC;
                            res_end_block_next = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = phase_dec;
                    end
                    state_next = lit_valid ? lz4bd_pkg::SQ_CNT : lz4bd_pkg::SQ_PUT;
                end
            end

            lz4bd_pkg::SQ_RD:
            begin
                win_rd_en     = 1'b1;
                read_ptr_next = read_ptr_reg + AW'(1);
                state_next    = lz4bd_pkg::SQ_CWR;
            end

            lz4bd_pkg::SQ_CWR:
            begin
                // Copy the byte read last cycle back into the window; overlapping
                // matches see it on the next read.
                win_wr_en          = 1'b1;
                win_wr_data        = win_rd_data;
                write_ptr_next     = write_ptr_reg + AW'(1);
                alu_req.op         = lz4bd_pkg::ALU_SUB;
                alu_req.a          = match_left_reg;
                alu_req.b          = LW'(1);
                match_left_next    = alu_rsp.result;
                res_byte_next      = win_rd_data;
                res_valid_next     = 1'b1;
                res_status_next    = lz4bd_pkg::STS_OK;
                if (alu_rsp.result == '0)
                begin
                    phase_next         = lz4bd_pkg::PH_TOKEN;
                    res_done_next      = end_seen_reg;
                    res_end_block_next = end_seen_reg;
                    res_run_end_next   = 1'b1;
                end
                else
                begin
                    res_done_next      = 1'b0;
                    res_end_block_next = 1'b0;
                    res_run_end_next   = (burst_cnt_reg == BW'(lz4bd_pkg::DRAIN_BURST - 1));
                end
                state_next = lz4bd_pkg::SQ_CNT;
            end

            lz4bd_pkg::SQ_CNT:
            begin
                alu_req.op         = lz4bd_pkg::ALU_INC;
                alu_req.a          = emitted_count_reg;
                emitted_count_next = alu_rsp.result;
                state_next         = lz4bd_pkg::SQ_PUT;
            end

            lz4bd_pkg::SQ_PUT:
            begin
                if (put_ok)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, emitted_count_reg,
                                      (phase_reg == lz4bd_pkg::PH_COPY),
                                      res_done_reg, res_status_reg, res_byte_reg};
                    out_user_next  = res_valid_reg;
                    out_last_next  = res_run_end_reg;
                    if (res_end_block_reg)
                    begin
                        // Block end: counters restart, window and pointers are kept.
                        phase_next         = lz4bd_pkg::PH_TOKEN;
                        literal_left_next  = '0;
                        match_left_next    = '0;
                        end_seen_next      = 1'b0;
                        emitted_count_next = '0;
                    end
                    if (res_run_end_reg)
                    begin
                        state_next = lz4bd_pkg::SQ_IDLE;
                    end
                    else
                    begin
                        burst_cnt_next = burst_cnt_reg + BW'(1);
                        state_next     = lz4bd_pkg::SQ_RD;
                    end
                end
            end

            default:
            begin
                state_next = lz4bd_pkg::SQ_IDLE;
            end
        endcase
    end

    // A pending copy always has bytes left to produce.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == lz4bd_pkg::PH_COPY) |-> (match_left_reg != '0))
        else $error("copy phase with no match bytes left");

    // The window is never asked to read and write in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(win_wr_en && win_rd_en))
        else $error("window read and write collide");

    // The output count restarts after a result that ends the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lz4bd_pkg::SQ_PUT && put_ok && res_end_block_reg)
        |=> (emitted_count_reg == '0 && phase_reg == lz4bd_pkg::PH_TOKEN))
        else $error("block end did not restart the decoder");

endmodule

/* rtl/lz4bd_alu.sv */
// Shared 32-bit adder: wrapping increment, saturating add and subtract with borrow.
module lz4bd_alu
(
    input  lz4bd_pkg::alu_req_t req,
    output lz4bd_pkg::alu_rsp_t rsp
);

    logic [lz4bd_pkg::LEN_W-1:0] b_eff;
    logic                        cin;
    logic [lz4bd_pkg::LEN_W:0]   sum;

    always_comb
    begin
        case (req.op)
            lz4bd_pkg::ALU_SUB:
            begin
                b_eff = ~req.b;
                cin   = 1'b1;
            end
            lz4bd_pkg::ALU_INC:
            begin
                b_eff = '0;
                cin   = 1'b1;
            end
            default:
            begin
                b_eff = req.b;
                cin   = 1'b0;
            end
        endcase
        sum = {1'b0, req.a} + {1'b0, b_eff} + {{lz4bd_pkg::LEN_W{1'b0}}, cin};
        rsp.carry = sum[lz4bd_pkg::LEN_W];
        // A saturating add clamps to all ones when the sum carries out.
        if (req.op == lz4bd_pkg::ALU_ADD_SAT && sum[lz4bd_pkg::LEN_W])
        begin
            rsp.result = '1;
        end
        else
        begin
            rsp.result = sum[lz4bd_pkg::LEN_W-1:0];
        end
    end

endmodule

/* rtl/lz4bd_window.sv */
// Ring history window: one write port and one registered read port.
module lz4bd_window
(
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [lz4bd_pkg::WIN_AW-1:0] wr_addr,
    input  logic [7:0]                   wr_data,
    input  logic                         rd_en,
    input  logic [lz4bd_pkg::WIN_AW-1:0] rd_addr,
    output logic [7:0]                   rd_data
);

    logic [7:0] mem [lz4bd_pkg::WINDOW_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
